// File: src/nscl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest seed color lookup package
// Shared widths, default parameter values and codes for the seed search block.
// ----------------------------------------------------------------------------
package nscl_pkg;

  localparam int MAX_SEEDS_DEF  = 256;
  localparam int COORD_BITS_DEF = 10;

  localparam int IDX_IN_W     = 8;
  localparam int COORD_IN_W   = 10;
  localparam int COLOR_W      = 32;
  localparam int DIST_W       = 28;
  localparam int SEED_COUNT_W = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 9;

  // Scale applied to the squared Euclidean distance
  localparam int DIST_SCALE = 100;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic {
    MODE_EUCLID    = 1'b0,
    MODE_MANHATTAN = 1'b1
  } dist_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED_COUNT    = 1'b0,
    CFG_DISTANCE_MODE = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

endpackage
`default_nettype wire

// File: src/nscl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest seed color lookup channels
// Input item, result item and configuration write channels (valid/ready).
// ----------------------------------------------------------------------------
interface nscl_in_if import nscl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [IDX_IN_W-1:0]   entry_index;
  logic [COORD_IN_W-1:0] coord_x;
  logic [COORD_IN_W-1:0] coord_y;
  logic [COLOR_W-1:0]    entry_color;

  modport source (output valid, action, entry_index, coord_x, coord_y, entry_color,
                  input ready);
  modport sink   (input valid, action, entry_index, coord_x, coord_y, entry_color,
                  output ready);
endinterface

interface nscl_out_if import nscl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  pixel_color;
  logic [IDX_IN_W-1:0] nearest_index;
  logic [DIST_W-1:0]   best_distance;
  logic                found;

  modport source (output valid, pixel_color, nearest_index, best_distance, found,
                  input ready);
  modport sink   (input valid, pixel_color, nearest_index, best_distance, found,
                  output ready);
endinterface

interface nscl_cfg_if import nscl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/nearest_seed_color_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: accepted back to back while idle, no result.
// Query: for n = min(seed_count, MAX_SEEDS) seeds, the read port, abs diff and square
//   or sum registers feed the compare; the single distance pipe takes one seed a cycle
//   from the seed memory read port. Next item accepted once the result is registered.
// Reset clears config (seed_count = 0, Euclidean mode) and control; the seed
//   memory is not cleared and must be loaded before it is searched.
// ----------------------------------------------------------------------------
// Nearest seed color lookup unit
// Seed table with a brute-force nearest seed search over a shared distance pipe.
// ----------------------------------------------------------------------------
module nearest_seed_color_lookup_unit import nscl_pkg::*; #(
  parameter int MAX_SEEDS  = MAX_SEEDS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nscl_in_if.sink     in_i,
  nscl_out_if.source  out_o,
  nscl_cfg_if.sink    cfg_i
);

  localparam int CW    = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
  localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam int SQ_W  = 2 * CW + 1;

  // Configuration
  logic [SEED_COUNT_W-1:0] seed_count_q;
  dist_mode_e              mode_q;

  // Control
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   k_q, n_q, n_lim;
  logic               v1_q, v2_q, v3_q;
  logic               found_q;
  logic               out_valid_q, out_valid_d;
  logic               in_rdy;
  logic               in_xfer, query_start, load_wr, rd_en, finish, pipe_empty;

  // Seed memory
  logic [CW-1:0]      mem_x [MAX_SEEDS];
  logic [CW-1:0]      mem_y [MAX_SEEDS];
  logic [COLOR_W-1:0] mem_c [MAX_SEEDS];
  logic [IDX_W-1:0]   wr_addr, rd_addr;

  // Pipe payload
  logic [CW-1:0]      px_q, py_q;
  logic [CW-1:0]      rd_x_q, rd_y_q;
  logic [COLOR_W-1:0] rd_c_q, col2_q, col3_q;
  logic [IDX_W-1:0]   idx1_q, idx2_q, idx3_q;
  logic [CW-1:0]      dx_q, dy_q;
  logic [SQ_W-1:0]    sq_q;
  logic [DIST_W-1:0]  seed_dist;
  logic               better;
  logic [DIST_W-1:0]  best_d_q;
  logic [IDX_W-1:0]   best_k_q;
  logic [COLOR_W-1:0] best_c_q;

  // Result register
  logic [COLOR_W-1:0]  out_color_q;
  logic [IDX_IN_W-1:0] out_index_q;
  logic [DIST_W-1:0]   out_dist_q;
  logic                out_found_q;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_count_q <= '0;
      mode_q       <= MODE_EUCLID;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_SEED_COUNT:    seed_count_q <= cfg_i.data;
        CFG_DISTANCE_MODE: mode_q       <= dist_mode_e'(cfg_i.data[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(seed_count_q) > MAX_SEEDS) begin
      n_lim = CNT_W'(MAX_SEEDS);
    end else begin
      n_lim = CNT_W'(seed_count_q);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and sequencer
  // --------------------------------------------------------------------------
  assign in_xfer     = in_i.valid && in_i.ready;
  assign query_start = in_xfer && (in_i.action == ACT_QUERY);
  assign load_wr     = in_xfer && (in_i.action == ACT_LOAD) &&
                       (int'(in_i.entry_index) < MAX_SEEDS);
  assign rd_en       = (state_q == ST_SEARCH) && (k_q != n_q);
  assign pipe_empty  = !(v1_q || v2_q || v3_q);
  assign finish      = (state_q == ST_SEARCH) && (k_q == n_q) && pipe_empty &&
                       (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (query_start) state_d = ST_SEARCH;
      ST_SEARCH: if (finish) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_IDLE: in_rdy = 1'b1;
      default: in_rdy = 1'b0;
    endcase
  end

  assign in_i.ready = in_rdy;

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      n_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      v1_q        <= rd_en;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      if (query_start) begin
        k_q     <= '0;
        n_q     <= n_lim;
        found_q <= 1'b0;
      end else begin
        if (rd_en) k_q <= k_q + 1'b1;
        if (better) found_q <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Seed memory: one write port for loads, one registered read port for search
  // --------------------------------------------------------------------------
  assign wr_addr = IDX_W'(in_i.entry_index);
  assign rd_addr = k_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      mem_x[wr_addr] <= in_i.coord_x[CW-1:0];
      mem_y[wr_addr] <= in_i.coord_y[CW-1:0];
      mem_c[wr_addr] <= in_i.entry_color;
    end
    if (rd_en) begin
      rd_x_q <= mem_x[rd_addr];
      rd_y_q <= mem_y[rd_addr];
      rd_c_q <= mem_c[rd_addr];
      idx1_q <= rd_addr;
    end
  end

  // --------------------------------------------------------------------------
  // Distance pipe: abs diff, square and scale or sum, and compare
  // --------------------------------------------------------------------------
  always_comb begin
    if (mode_q == MODE_MANHATTAN) begin
      seed_dist = DIST_W'(sq_q);
    end else begin
      seed_dist = DIST_W'(sq_q) * DIST_W'(DIST_SCALE);
    end
  end

  // Strictly less keeps the lowest index on ties
  assign better = v3_q && (!found_q || (seed_dist < best_d_q));

  always_ff @(posedge clk_i) begin
    if (query_start) begin
      px_q <= in_i.coord_x[CW-1:0];
      py_q <= in_i.coord_y[CW-1:0];
    end
    if (v1_q) begin
      dx_q   <= (px_q >= rd_x_q) ? (px_q - rd_x_q) : (rd_x_q - px_q);
      dy_q   <= (py_q >= rd_y_q) ? (py_q - rd_y_q) : (rd_y_q - py_q);
      idx2_q <= idx1_q;
      col2_q <= rd_c_q;
    end
    if (v2_q) begin
      if (mode_q == MODE_MANHATTAN) begin
        sq_q <= SQ_W'(dx_q) + SQ_W'(dy_q);
      end else begin
        sq_q <= (SQ_W'(dx_q) * SQ_W'(dx_q)) + (SQ_W'(dy_q) * SQ_W'(dy_q));
      end
      idx3_q <= idx2_q;
      col3_q <= col2_q;
    end
    if (better) begin
      best_d_q <= seed_dist;
      best_k_q <= idx3_q;
      best_c_q <= col3_q;
    end
    if (finish) begin
      out_color_q <= found_q ? best_c_q : '0;
      out_index_q <= found_q ? IDX_IN_W'(best_k_q) : '0;
      out_dist_q  <= found_q ? best_d_q : '0;
      out_found_q <= found_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_color   = out_color_q;
  assign out_o.nearest_index = out_index_q;
  assign out_o.best_distance = out_dist_q;
  assign out_o.found         = out_found_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> pipe_empty)
    else $error("distance pipe busy while accepting input");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (k_q <= n_q))
    else $error("seed scan ran past seed count");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished search did not register a result");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> ((out_color_q == '0) && (out_dist_q == '0) &&
                                       (out_index_q == '0)))
    else $error("empty search returned nonzero fields");

  a_no_result_without_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SEARCH))
    else $error("result appeared without a search");

endmodule
`default_nettype wire

// File: tb/nscl_nearest_seed_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest seed result monitor
// Watches the input, result and configuration channels. It keeps a copy of the
// seed table and of the settings, works out the nearest seed for every query
// it sees accepted, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module nscl_nearest_seed_monitor import nscl_pkg::*; #(
  parameter int MAX_SEEDS  = MAX_SEEDS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  nscl_in_if   in_mon,
  nscl_out_if  out_mon,
  nscl_cfg_if  cfg_mon,
  output int   pending_o,
  output int   fail_count_o
);

  localparam int unsigned       COORD_MASK = (1 << COORD_BITS) - 1;
  localparam longint unsigned   DIST_LIMIT = (64'd1 << DIST_W) - 1;
  localparam int                PRINT_CAP  = 100;

  typedef struct packed {
    logic [COLOR_W-1:0]  pixel_color;
    logic [IDX_IN_W-1:0] nearest_index;
    logic [DIST_W-1:0]   best_distance;
    logic                found;
  } pixel_result_t;

  int unsigned                seed_x     [MAX_SEEDS];
  int unsigned                seed_y     [MAX_SEEDS];
  logic [COLOR_W-1:0]         seed_color [MAX_SEEDS];
  logic [SEED_COUNT_W-1:0]    seed_count_q;
  dist_mode_e                 mode_q;
  pixel_result_t              expected_pixels[$];
  pixel_result_t              want;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned exp_val);
    if (fail_count_o < PRINT_CAP) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
               exp_val);
    end
    fail_count_o++;
  endtask

  // Scan seeds in order; a later seed must be strictly nearer to win.
  function automatic pixel_result_t nearest_seed(int unsigned px, int unsigned py);
    pixel_result_t   res;
    int unsigned     n;
    int unsigned     best_k;
    longint unsigned dx, dy, d, best_d;
    bit              hit;
    res    = '0;
    hit    = 1'b0;
    best_d = 0;
    best_k = 0;
    n      = (seed_count_q > MAX_SEEDS) ? MAX_SEEDS : seed_count_q;
    for (int unsigned k = 0; k < n; k++) begin
      dx = (px > seed_x[k]) ? longint'(px - seed_x[k]) : longint'(seed_x[k] - px);
      dy = (py > seed_y[k]) ? longint'(py - seed_y[k]) : longint'(seed_y[k] - py);
      if (mode_q == MODE_MANHATTAN) d = dx + dy;
      else d = (dx * dx + dy * dy) * DIST_SCALE;
      if (!hit || d < best_d) begin
        hit    = 1'b1;
        best_d = d;
        best_k = k;
      end
    end
    if (best_d > DIST_LIMIT) best_d = DIST_LIMIT;
    if (hit) begin
      res.pixel_color   = seed_color[best_k];
      res.nearest_index = best_k[IDX_IN_W-1:0];
      res.best_distance = best_d[DIST_W-1:0];
      res.found         = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_count_q = '0;
      mode_q       = MODE_EUCLID;
      expected_pixels.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          flag_mismatch("result with nothing outstanding", out_mon.pixel_color, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_mon.pixel_color !== want.pixel_color)
            flag_mismatch("pixel_color", out_mon.pixel_color, want.pixel_color);
          if (out_mon.nearest_index !== want.nearest_index)
            flag_mismatch("nearest_index", out_mon.nearest_index, want.nearest_index);
          if (out_mon.best_distance !== want.best_distance)
            flag_mismatch("best_distance", out_mon.best_distance, want.best_distance);
          if (out_mon.found !== want.found)
            flag_mismatch("found", out_mon.found, want.found);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_e'(cfg_mon.index))
          CFG_SEED_COUNT:    seed_count_q = cfg_mon.data[SEED_COUNT_W-1:0];
          CFG_DISTANCE_MODE: mode_q = dist_mode_e'(cfg_mon.data[0]);
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACT_LOAD) begin
          if (in_mon.entry_index < MAX_SEEDS) begin
            seed_x[in_mon.entry_index]     = in_mon.coord_x & COORD_MASK;
            seed_y[in_mon.entry_index]     = in_mon.coord_y & COORD_MASK;
            seed_color[in_mon.entry_index] = in_mon.entry_color;
          end
        end else begin
          expected_pixels.push_back(nearest_seed(in_mon.coord_x & COORD_MASK,
                                                 in_mon.coord_y & COORD_MASK));
        end
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

// File: tb/tb_nearest_seed_color_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest seed color lookup unit testbench
// Loads seed tables, runs directed corner queries, then random phases of loads
// and queries under changing seed counts and distance metrics, with random
// stalls on both sides and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_nearest_seed_color_lookup_unit;
  import nscl_pkg::*;

  localparam int ITEM_TARGET     = 1200;
  localparam int PHASE_ITEMS     = 30;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int SETTLE_CYCLES   = 10;
  localparam int TAIL_CYCLES     = 300;
  localparam int DRAIN_LIMIT     = 50000;
  localparam int COORD_TOP       = (1 << COORD_IN_W) - 1;

  logic clk_i;
  logic rst_ni;
  int   pending;
  int   fails;
  int   items_sent;
  bit   steady;
  bit   hold_off_armed;
  bit   hold_off_done;
  int unsigned           live_seeds;
  logic [COORD_IN_W-1:0] shadow_x [MAX_SEEDS_DEF];
  logic [COORD_IN_W-1:0] shadow_y [MAX_SEEDS_DEF];

  nscl_in_if  pixel_in ();
  nscl_out_if pixel_out ();
  nscl_cfg_if cfg_ch ();

  nearest_seed_color_lookup_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pixel_in),
    .out_o  (pixel_out),
    .cfg_i  (cfg_ch)
  );

  nscl_nearest_seed_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (pixel_in),
    .out_mon      (pixel_out),
    .cfg_mon      (cfg_ch),
    .pending_o    (pending),
    .fail_count_o (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL nearest_seed_color_lookup_unit");
    $finish;
  end

  // Result side: random stalls, one long hold-off once armed.
  initial begin
    pixel_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_armed && !hold_off_done) begin
        pixel_out.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        pixel_out.ready <= steady || ($urandom_range(99) >= 6);
      end
    end
  end

  // Offer one item from a falling edge, hold it until transferred.
  task automatic offer_item(action_e act, logic [IDX_IN_W-1:0] idx,
                            logic [COORD_IN_W-1:0] x, logic [COORD_IN_W-1:0] y,
                            logic [COLOR_W-1:0] color);
    while (!steady && $urandom_range(99) < 6) begin
      pixel_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pixel_in.valid       <= 1'b1;
    pixel_in.action      <= act;
    pixel_in.entry_index <= idx;
    pixel_in.coord_x     <= x;
    pixel_in.coord_y     <= y;
    pixel_in.entry_color <= color;
    do @(posedge clk_i); while (!pixel_in.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_seed(logic [IDX_IN_W-1:0] idx, logic [COORD_IN_W-1:0] x,
                           logic [COORD_IN_W-1:0] y, logic [COLOR_W-1:0] color);
    shadow_x[idx] = x;
    shadow_y[idx] = y;
    offer_item(ACT_LOAD, idx, x, y, color);
  endtask

  // Ignored fields carry random values on queries.
  task automatic query_pixel(logic [COORD_IN_W-1:0] x, logic [COORD_IN_W-1:0] y);
    offer_item(ACT_QUERY, IDX_IN_W'($urandom_range(MAX_SEEDS_DEF - 1)), x, y, $urandom());
  endtask

  task automatic write_register(cfg_reg_e which, int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
    if (which == CFG_SEED_COUNT)
      live_seeds = (value > MAX_SEEDS_DEF) ? MAX_SEEDS_DEF : value;
  endtask

  // Drop valid, wait for every outstanding result, then let trailing loads finish.
  task automatic wait_results_drained();
    int waited;
    pixel_in.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [COORD_IN_W-1:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 7) return '0;
    if (r < 14) return COORD_IN_W'(COORD_TOP);
    return COORD_IN_W'($urandom_range(COORD_TOP));
  endfunction

  initial begin
    int          p, k, j, r;
    int unsigned count;
    rst_ni               = 1'b0;
    steady               = 1'b0;
    hold_off_armed       = 1'b0;
    hold_off_done        = 1'b0;
    items_sent           = 0;
    live_seeds           = 0;
    pixel_in.valid       = 1'b0;
    pixel_in.action      = ACT_LOAD;
    pixel_in.entry_index = '0;
    pixel_in.coord_x     = '0;
    pixel_in.coord_y     = '0;
    pixel_in.entry_color = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_SEED_COUNT;
    cfg_ch.data          = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Zero seeds after reset: nothing found.
    query_pixel(0, 0);
    query_pixel(COORD_TOP, COORD_TOP);

    // Corners, duplicate positions and equidistant neighbors.
    load_seed(0, 0, 0, 32'h0000_0000);
    load_seed(1, COORD_TOP, COORD_TOP, 32'hFFFF_FFFF);
    load_seed(2, 0, COORD_TOP, 32'hA5A5_A5A5);
    load_seed(3, COORD_TOP, 0, 32'h5A5A_5A5A);
    load_seed(4, 512, 512, 32'h1234_5678);
    load_seed(5, 512, 512, 32'h8765_4321);
    load_seed(6, 511, 513, 32'h00FF_00FF);
    load_seed(7, 513, 511, 32'hFF00_FF00);
    wait_results_drained();
    write_register(CFG_SEED_COUNT, 8);
    query_pixel(0, 0);
    query_pixel(COORD_TOP, COORD_TOP);
    query_pixel(512, 512);
    query_pixel(512, 511);
    query_pixel(700, 300);
    wait_results_drained();
    write_register(CFG_DISTANCE_MODE, MODE_MANHATTAN);
    query_pixel(512, 512);
    query_pixel(COORD_TOP, 0);
    query_pixel(511, 512);
    query_pixel(0, COORD_TOP);

    // Single seed at the far corner: largest distance in each metric.
    wait_results_drained();
    write_register(CFG_SEED_COUNT, 1);
    query_pixel(COORD_TOP, COORD_TOP);
    wait_results_drained();
    write_register(CFG_DISTANCE_MODE, MODE_EUCLID);
    query_pixel(COORD_TOP, COORD_TOP);

    // Fill the whole table so every later search reads written entries.
    wait_results_drained();
    for (k = 0; k < MAX_SEEDS_DEF; k++)
      load_seed(IDX_IN_W'(k), pick_coord(), pick_coord(), $urandom());

    p = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_results_drained();
      steady = (p >= 6 && p < 11);
      if (p == 3) hold_off_armed = 1'b1;
      case (p)
        0: count = MAX_SEEDS_DEF;
        1: count = (1 << SEED_COUNT_W) - 1;
        2: count = 0;
        default: begin
          r = $urandom_range(99);
          if (r < 10) count = 0;
          else if (r < 15) count = MAX_SEEDS_DEF;
          else if (r < 18) count = $urandom_range((1 << SEED_COUNT_W) - 1, MAX_SEEDS_DEF + 1);
          else if (r < 25) count = $urandom_range(MAX_SEEDS_DEF - 1, 17);
          else count = $urandom_range(16, 1);
        end
      endcase
      write_register(CFG_SEED_COUNT, count);
      write_register(CFG_DISTANCE_MODE, $urandom_range(1));
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(9);
        if ($urandom_range(99) < 60) begin
          // Hit a seed exactly or one step off it, else anywhere.
          if (r < 2 && live_seeds != 0) begin
            j = $urandom_range(live_seeds - 1);
            query_pixel(shadow_x[j], COORD_IN_W'(shadow_y[j] + r));
          end else begin
            query_pixel(pick_coord(), pick_coord());
          end
        end else begin
          if (live_seeds != 0 && $urandom_range(1))
            k = $urandom_range(live_seeds - 1);
          else
            k = $urandom_range(MAX_SEEDS_DEF - 1);
          // Copy another seed's position now and then to force ties.
          if (r == 0) begin
            j = $urandom_range(MAX_SEEDS_DEF - 1);
            load_seed(IDX_IN_W'(k), shadow_x[j], shadow_y[j], $urandom());
          end else begin
            load_seed(IDX_IN_W'(k), pick_coord(), pick_coord(), $urandom());
          end
        end
      end
      p++;
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("PASS nearest_seed_color_lookup_unit");
    end else begin
      $display("FAIL nearest_seed_color_lookup_unit");
    end
    $finish;
  end

endmodule
